// ----- src/qbt_pkg.sv -----
`default_nettype none

package qbt_pkg;

   localparam int SEGMENTS_DEFAULT = 30;
   localparam int QUEUE_DEPTH = 2;

   localparam int COORD_W = 32;
   localparam int WFRAC = 30;
   localparam int WEIGHT_W = WFRAC + 1;
   localparam int PROD_W = 2 * COORD_W;
   localparam int ROUND_W = PROD_W - WFRAC;
   localparam int SUM_W = ROUND_W + 1;
   localparam int AXES = 3;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (WFRAC - 1));

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [AXES-1:0] point_type;

   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
   } curve_type;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'b001,
      PH_CONTROL = 3'b010,
      PH_END     = 3'b100
   } phase_type;

   // product in q16.16 x q2.30, rounded to nearest q16.16, ties up
   function automatic logic signed [ROUND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + ROUND_HALF;
      return $signed(s[PROD_W-1:WFRAC]);
   endfunction

   function automatic coord_type sat32(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] top;
      top = v[SUM_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
         return v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/quadratic_bezier_path_tessellator.sv -----
// quadratic bezier path tessellator
//
// req channel: one 3d point per item, signed q16.16. the first point after
// reset starts the chain; after that points alternate control, end. an end
// point closes a curve and becomes the start of the next one.
// rsp channel: SEGMENTS line segments per closed curve, start and end in
// q16.16, last_segment high on the final segment of the curve.
// the first segment of a curve follows its end point through the curve queue,
// the sequencer and the evaluator stages; the rest follow one per cycle
// while rsp_ready is high. the evaluator computes one curve point per cycle
// while the receiver does not stall it, for k = 0 .. SEGMENTS of each curve.
// a two-entry curve queue sits between the point front end and the evaluator,
// so points keep being accepted while earlier curves are drawn out.
// reset (synchronous, active high) clears the chain to "no point yet", with
// start and control at zero, and drops all queued and pending segments.
// a stalled receiver freezes the evaluator pipeline; the front end stalls
// only when an end point arrives with the queue full.
`default_nettype none

module quadratic_bezier_path_tessellator #(
   parameter int SEGMENTS = qbt_pkg::SEGMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qbt_pkg::coord_type   req_point_x,
   input  qbt_pkg::coord_type   req_point_y,
   input  qbt_pkg::coord_type   req_point_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qbt_pkg::coord_type   rsp_start_x,
   output qbt_pkg::coord_type   rsp_start_y,
   output qbt_pkg::coord_type   rsp_start_z,
   output qbt_pkg::coord_type   rsp_end_x,
   output qbt_pkg::coord_type   rsp_end_y,
   output qbt_pkg::coord_type   rsp_end_z,
   output logic                 rsp_last_segment
);

   logic               push_valid;
   logic               push_ready;
   qbt_pkg::curve_type push_curve;
   logic               pop_valid;
   logic               pop_ready;
   qbt_pkg::curve_type pop_curve;

   qbt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_curve  (push_curve)
   );

   qbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_curve (push_curve),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_curve  (pop_curve)
   );

   qbt_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_curve        (pop_curve),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_start_z      (rsp_start_z),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_z        (rsp_end_z),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

`default_nettype wire

// ----- src/qbt_front.sv -----
`default_nettype none

module qbt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qbt_pkg::coord_type   req_point_x,
   input  qbt_pkg::coord_type   req_point_y,
   input  qbt_pkg::coord_type   req_point_z,
   output logic                 push_valid,
   input  logic                 push_ready,
   output qbt_pkg::curve_type   push_curve
);

   qbt_pkg::phase_type phase_ff, phase_in;
   qbt_pkg::point_type start_ff, start_in;
   qbt_pkg::point_type control_ff, control_in;
   qbt_pkg::point_type point;
   logic               accept;
   logic               at_end;

   always_comb begin
      point[0] = req_point_x;
      point[1] = req_point_y;
      point[2] = req_point_z;
   end

   assign at_end     = (phase_ff == qbt_pkg::PH_END);
   assign req_ready  = !at_end || push_ready;
   assign push_valid = req_valid && at_end;
   assign accept     = req_valid && req_ready;

   always_comb begin
      push_curve.p0 = start_ff;
      push_curve.p1 = control_ff;
      push_curve.p2 = point;
   end

   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      control_in = control_ff;
      if (accept) begin
         unique case (phase_ff)
            qbt_pkg::PH_FIRST: begin
               start_in = point;
               phase_in = qbt_pkg::PH_CONTROL;
            end
            qbt_pkg::PH_CONTROL: begin
               control_in = point;
               phase_in   = qbt_pkg::PH_END;
            end
            qbt_pkg::PH_END: begin
               start_in = point;
               phase_in = qbt_pkg::PH_CONTROL;
            end
            default: begin
               control_in = point;
               phase_in   = qbt_pkg::PH_END;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= qbt_pkg::PH_FIRST;
         start_ff   <= '0;
         control_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         control_ff <= control_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/qbt_queue.sv -----
`default_nettype none

module qbt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  qbt_pkg::curve_type   push_curve,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output qbt_pkg::curve_type   pop_curve
);

   localparam int DEPTH = qbt_pkg::QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   qbt_pkg::curve_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_curve  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_curve;
      end
   end

endmodule

`default_nettype wire

// ----- src/qbt_back.sv -----
`default_nettype none

module qbt_back #(
   parameter int SEGMENTS = qbt_pkg::SEGMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  qbt_pkg::curve_type   pop_curve,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qbt_pkg::coord_type   rsp_start_x,
   output qbt_pkg::coord_type   rsp_start_y,
   output qbt_pkg::coord_type   rsp_start_z,
   output qbt_pkg::coord_type   rsp_end_x,
   output qbt_pkg::coord_type   rsp_end_y,
   output qbt_pkg::coord_type   rsp_end_z,
   output logic                 rsp_last_segment
);

   localparam int KW = $clog2(SEGMENTS + 1);
   localparam int WW = qbt_pkg::WEIGHT_W;
   localparam int PW = qbt_pkg::PROD_W;
   localparam int RW = qbt_pkg::ROUND_W;
   localparam int SW = qbt_pkg::SUM_W;
   localparam int AXES = qbt_pkg::AXES;
   localparam logic [KW-1:0] K_LAST = KW'(SEGMENTS);

   // bernstein weights at t = k/SEGMENTS in unsigned q1.30
   logic [WW-1:0] w0_tab [SEGMENTS+1];
   logic [WW-1:0] w1_tab [SEGMENTS+1];
   logic [WW-1:0] w2_tab [SEGMENTS+1];

   for (genvar g = 0; g <= SEGMENTS; g++) begin : g_weight
      localparam longint unsigned DEN = longint'(SEGMENTS) * longint'(SEGMENTS);
      localparam longint unsigned N0 = longint'(SEGMENTS - g) * longint'(SEGMENTS - g);
      localparam longint unsigned N1 = 2 * longint'(SEGMENTS - g) * longint'(g);
      localparam longint unsigned N2 = longint'(g) * longint'(g);
      localparam longint unsigned Q0 = ((N0 << qbt_pkg::WFRAC) + DEN / 2) / DEN;
      localparam longint unsigned Q1 = ((N1 << qbt_pkg::WFRAC) + DEN / 2) / DEN;
      localparam longint unsigned Q2 = ((N2 << qbt_pkg::WFRAC) + DEN / 2) / DEN;
      assign w0_tab[g] = WW'(Q0);
      assign w1_tab[g] = WW'(Q1);
      assign w2_tab[g] = WW'(Q2);
   end

   logic                        hold;
   logic                        advance;
   logic                        issue;
   logic                        last_issue;
   logic                        pop_take;

   logic                        busy_ff, busy_in;
   logic [KW-1:0]               k_ff, k_in;
   qbt_pkg::curve_type          curve_ff, curve_in;

   logic                        v1_ff;
   logic [KW-1:0]               k1_ff;
   logic signed [PW-1:0]        prod_ff [AXES][3];
   logic signed [PW-1:0]        prod_in [AXES][3];

   logic                        v2_ff;
   logic [KW-1:0]               k2_ff;
   qbt_pkg::coord_type          acc2_ff [AXES];
   qbt_pkg::coord_type          acc2_in [AXES];
   logic signed [RW-1:0]        r2_ff [AXES];
   logic signed [RW-1:0]        r2_in [AXES];

   qbt_pkg::point_type          pt_in;
   qbt_pkg::point_type          prev_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   qbt_pkg::point_type          rsp_start_ff;
   qbt_pkg::point_type          rsp_end_ff;
   logic                        rsp_last_ff;

   assign hold       = rsp_valid_ff && !rsp_ready;
   assign advance    = !hold;
   assign issue      = busy_ff && advance;
   assign last_issue = issue && (k_ff == K_LAST);
   assign pop_ready  = advance && (!busy_ff || last_issue);
   assign pop_take   = pop_valid && pop_ready;

   // sequencer over k = 0 .. SEGMENTS
   always_comb begin
      busy_in  = busy_ff;
      k_in     = k_ff;
      curve_in = curve_ff;
      if (pop_take) begin
         busy_in  = 1'b1;
         k_in     = '0;
         curve_in = pop_curve;
      end else if (last_issue) begin
         busy_in = 1'b0;
      end else if (issue) begin
         k_in = k_ff + KW'(1);
      end
   end

   // stage 1: nine products
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         prod_in[a][0] = $signed(curve_ff.p0[a]) * $signed({1'b0, w0_tab[k_ff]});
         prod_in[a][1] = $signed(curve_ff.p1[a]) * $signed({1'b0, w1_tab[k_ff]});
         prod_in[a][2] = $signed(curve_ff.p2[a]) * $signed({1'b0, w2_tab[k_ff]});
      end
   end

   // stage 2: round, first saturating add
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         acc2_in[a] = qbt_pkg::sat32(SW'(qbt_pkg::round_q30(prod_ff[a][0]))
                                   + SW'(qbt_pkg::round_q30(prod_ff[a][1])));
         r2_in[a]   = qbt_pkg::round_q30(prod_ff[a][2]);
      end
   end

   // stage 3: second saturating add
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pt_in[a] = qbt_pkg::sat32(SW'($signed(acc2_ff[a])) + SW'($signed(r2_ff[a])));
      end
   end

   assign rsp_valid_in = advance ? (v2_ff && (k2_ff != '0)) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      curve_ff <= curve_in;
      if (advance) begin
         k1_ff        <= k_ff;
         prod_ff      <= prod_in;
         k2_ff        <= k1_ff;
         acc2_ff      <= acc2_in;
         r2_ff        <= r2_in;
         rsp_start_ff <= prev_ff;
         rsp_end_ff   <= pt_in;
         rsp_last_ff  <= (k2_ff == K_LAST);
         if (v2_ff) begin
            prev_ff <= pt_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = rsp_start_ff[0];
   assign rsp_start_y      = rsp_start_ff[1];
   assign rsp_start_z      = rsp_start_ff[2];
   assign rsp_end_x        = rsp_end_ff[0];
   assign rsp_end_y        = rsp_end_ff[1];
   assign rsp_end_z        = rsp_end_ff[2];
   assign rsp_last_segment = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/qbt_checker.sv -----
`default_nettype none

module qbt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input qbt_pkg::coord_type   req_point_x,
   input qbt_pkg::coord_type   req_point_y,
   input qbt_pkg::coord_type   req_point_z,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input qbt_pkg::coord_type   rsp_start_x,
   input qbt_pkg::coord_type   rsp_start_y,
   input qbt_pkg::coord_type   rsp_start_z,
   input qbt_pkg::coord_type   rsp_end_x,
   input qbt_pkg::coord_type   rsp_end_y,
   input qbt_pkg::coord_type   rsp_end_z,
   input logic                 rsp_last_segment
);

   logic [3*qbt_pkg::COORD_W-1:0] req_point;
   assign req_point = {req_point_x, req_point_y, req_point_z};

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_x) && $stable(rsp_end_x)
         && $stable(rsp_start_y) && $stable(rsp_end_y) && $stable(rsp_start_z)
         && $stable(rsp_end_z) && $stable(rsp_last_segment))
      else $error("rsp item changed while stalled");

   // segments of one curve join end to start
   a_rsp_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_segment |=> !rsp_valid
         || (rsp_start_x == $past(rsp_end_x) && rsp_start_y == $past(rsp_end_y)
             && rsp_start_z == $past(rsp_end_z)))
      else $error("segment does not continue previous one");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // the first point of a chain never waits
   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

   a_req_x: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_point))
      else $error("stalled req item changed");

endmodule

bind quadratic_bezier_path_tessellator qbt_checker u_checker (.*);

`default_nettype wire

// ----- dv/tessellator_checker.sv -----
`timescale 1ns / 1ps

module tessellator_checker #(
   parameter int SEGMENTS = qbt_pkg::SEGMENTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  qbt_pkg::coord_type req_point_x,
   input  qbt_pkg::coord_type req_point_y,
   input  qbt_pkg::coord_type req_point_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  qbt_pkg::coord_type rsp_start_x,
   input  qbt_pkg::coord_type rsp_start_y,
   input  qbt_pkg::coord_type rsp_start_z,
   input  qbt_pkg::coord_type rsp_end_x,
   input  qbt_pkg::coord_type rsp_end_y,
   input  qbt_pkg::coord_type rsp_end_z,
   input  logic               rsp_last_segment,
   output int                 fail_count,
   output int                 segments_due
);

   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      qbt_pkg::point_type seg_start;
      qbt_pkg::point_type seg_end;
      logic               closing;
   } segment_type;

   segment_type        pending_segments[$];
   segment_type        expected_seg;
   segment_type        built_seg;
   qbt_pkg::point_type origin;
   qbt_pkg::point_type bend;
   qbt_pkg::point_type arrival;
   qbt_pkg::point_type got_start;
   qbt_pkg::point_type got_end;
   qbt_pkg::phase_type chain;
   int                 errors = 0;

   // bernstein weight num / (S*S) in q2.30, nearest, ties up
   function automatic longint bernstein_weight(longint num);
      longint den;
      den = longint'(SEGMENTS) * longint'(SEGMENTS);
      return ((num <<< qbt_pkg::WFRAC) + den / 2) / den;
   endfunction

   // q16.16 times q2.30 back to q16.16, nearest, ties toward +inf
   function automatic longint scaled_round(longint p, longint w);
      return (p * w + (64'sd1 <<< (qbt_pkg::WFRAC - 1))) >>> qbt_pkg::WFRAC;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic qbt_pkg::coord_type curve_point(int k, qbt_pkg::coord_type p0,
                                                      qbt_pkg::coord_type p1,
                                                      qbt_pkg::coord_type p2);
      longint w0, w1, w2, acc;
      w0 = bernstein_weight(longint'(SEGMENTS - k) * longint'(SEGMENTS - k));
      w1 = bernstein_weight(2 * longint'(SEGMENTS - k) * longint'(k));
      w2 = bernstein_weight(longint'(k) * longint'(k));
      acc = clamp32(scaled_round(p0, w0) + scaled_round(p1, w1));
      acc = clamp32(acc + scaled_round(p2, w2));
      return qbt_pkg::coord_type'(acc);
   endfunction

   task automatic compare_coord(string field, qbt_pkg::coord_type want,
                                qbt_pkg::coord_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_segments.delete();
         origin = '0;
         bend = '0;
         chain = qbt_pkg::PH_FIRST;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_start = {rsp_start_z, rsp_start_y, rsp_start_x};
            got_end = {rsp_end_z, rsp_end_y, rsp_end_x};
            if (pending_segments.size() == 0) begin
               $display("%0t: unexpected segment, expected none, actual %h %h last %b",
                        $time, got_start, got_end, rsp_last_segment);
               errors++;
            end else begin
               expected_seg = pending_segments.pop_front();
               for (int a = 0; a < qbt_pkg::AXES; a++) begin
                  compare_coord($sformatf("start[%0d]", a), expected_seg.seg_start[a],
                                got_start[a]);
                  compare_coord($sformatf("end[%0d]", a), expected_seg.seg_end[a],
                                got_end[a]);
               end
               compare_coord("last_segment", qbt_pkg::coord_type'(expected_seg.closing),
                             qbt_pkg::coord_type'(rsp_last_segment));
            end
         end
         if (req_valid && req_ready) begin
            arrival = {req_point_z, req_point_y, req_point_x};
            case (chain)
               qbt_pkg::PH_FIRST: begin
                  origin = arrival;
                  chain = qbt_pkg::PH_CONTROL;
               end
               qbt_pkg::PH_END: begin
                  for (int j = 0; j < SEGMENTS; j++) begin
                     for (int a = 0; a < qbt_pkg::AXES; a++) begin
                        built_seg.seg_start[a] = curve_point(j, origin[a], bend[a],
                                                             arrival[a]);
                        built_seg.seg_end[a] = curve_point(j + 1, origin[a], bend[a],
                                                           arrival[a]);
                     end
                     built_seg.closing = (j == SEGMENTS - 1);
                     pending_segments.insert(pending_segments.size(), built_seg);
                  end
                  origin = arrival;
                  chain = qbt_pkg::PH_CONTROL;
               end
               default: begin
                  bend = arrival;
                  chain = qbt_pkg::PH_END;
               end
            endcase
         end
      end
      segments_due <= pending_segments.size();
      fail_count <= errors;
   end

endmodule

// ----- dv/quadratic_bezier_path_tessellator_tb.sv -----
`timescale 1ns / 1ps

module quadratic_bezier_path_tessellator_tb;

   localparam int SEGMENTS = qbt_pkg::SEGMENTS_DEFAULT;
   localparam int RANDOM_POINTS = 210;
   localparam int CYCLE_LIMIT = 200000;
   localparam qbt_pkg::coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam qbt_pkg::coord_type C_MIN = 32'sh8000_0000;
   localparam qbt_pkg::coord_type C_ONE = 32'sh0001_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   qbt_pkg::coord_type req_point_x = '0;
   qbt_pkg::coord_type req_point_y = '0;
   qbt_pkg::coord_type req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   qbt_pkg::coord_type rsp_start_x, rsp_start_y, rsp_start_z;
   qbt_pkg::coord_type rsp_end_x, rsp_end_y, rsp_end_z;
   logic               rsp_last_segment;
   int                 fail_count;
   int                 segments_due;
   int                 cycles = 0;
   bit                 steady_sender = 1'b0;

   quadratic_bezier_path_tessellator #(.SEGMENTS(SEGMENTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_start_z      (rsp_start_z),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_z        (rsp_end_z),
      .rsp_last_segment (rsp_last_segment)
   );

   tessellator_checker #(.SEGMENTS(SEGMENTS)) segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_start_z      (rsp_start_z),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_z        (rsp_end_z),
      .rsp_last_segment (rsp_last_segment),
      .fail_count       (fail_count),
      .segments_due     (segments_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stalls, with a quiet window
   always @(posedge clock) begin
      rsp_ready <= (cycles >= 1500 && cycles < 3000) || $urandom_range(99) >= 6;
   end

   function automatic qbt_pkg::coord_type random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) return qbt_pkg::coord_type'($urandom);
      if (pick < 75) begin
         return qbt_pkg::coord_type'(int'($urandom_range(32'h0200_0000))
                                     - 32'h0100_0000);
      end
      if (pick < 90) begin
         case ($urandom_range(4))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            default: return C_ONE;
         endcase
      end
      if ($urandom_range(1)) return qbt_pkg::coord_type'(C_MAX - int'($urandom_range(255)));
      return qbt_pkg::coord_type'(C_MIN + int'($urandom_range(255)));
   endfunction

   task automatic send_point(input qbt_pkg::coord_type x, input qbt_pkg::coord_type y,
                             input qbt_pkg::coord_type z);
      while (!steady_sender && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segments_due != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_point('0, '0, '0);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MAX, C_MIN);
      send_point(C_MAX, C_MIN, C_MAX);
      send_point('1, '1, '1);
      send_point(32'sd1, 32'sd1, 32'sd1);
      send_point(C_ONE, -C_ONE, C_ONE);
      send_point(-C_ONE, C_ONE, -C_ONE);
      send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
      send_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MIN, C_MIN);
      wait_drained();

      for (int n = 0; n < RANDOM_POINTS; n++) begin
         steady_sender = (n >= 60 && n < 130);
         if (n == 150) wait_drained();
         send_point(random_coord(), random_coord(), random_coord());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
